@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the ray/cap intersection block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/rcci_pkg.sv @@
// ----------------------------------------------------------------------------
// rcci_pkg
// types, widths and divider helpers for the ray/cap intersection block
// ----------------------------------------------------------------------------
package rcci_pkg;

  // number format
  localparam int FRAC_BITS  = 16;
  localparam int WORD_WIDTH = 32;

  // internal widths
  localparam int NUM_W     = 54;                   // cap plane numerators
  localparam int DEN_W     = 38;                   // shared denominator
  localparam int DMAG_W    = DEN_W - 1;            // magnitude of denominator
  localparam int QUO_W     = WORD_WIDTH - 1;       // quotient bits below saturation
  localparam int DIV_SHIFT = QUO_W - FRAC_BITS;
  localparam int REM_W     = DMAG_W;
  localparam int OCC_W     = 34;                   // origin minus cap centre

  // item classification from the front end
  typedef enum logic [1:0] {
    CLS_BODY,
    CLS_PARALLEL,
    CLS_CAPS
  } cls_t;

  // configuration register file
  typedef struct packed {
    logic [2:0][31:0] center;
    logic [2:0][17:0] axis;
    logic [30:0]      radius;
    logic [30:0]      height;
  } cfg_t;

  // one queued item, front to back
  typedef struct packed {
    cls_t                   cls;
    logic [2:0][17:0]       dir;
    logic [2:0][OCC_W-1:0]  ocb;
    logic [2:0][OCC_W-1:0]  oct;
    logic [NUM_W-1:0]       num_b;
    logic [NUM_W-1:0]       num_t;
    logic [DEN_W-1:0]       den;
  } item_t;

  // one divider lane
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } dvl_t;

  // set up a lane: magnitude of the numerator, sign and divisor magnitude
  function automatic dvl_t div_init(logic [NUM_W-1:0] mag, logic neg,
                                    logic [DMAG_W-1:0] dm);
    dvl_t r;
    r.ovf = mag[NUM_W-1:DIV_SHIFT] >= (NUM_W - DIV_SHIFT)'(dm);
    r.rem = mag[DIV_SHIFT+REM_W-1:DIV_SHIFT];
    r.lo  = {mag[DIV_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    r.quo = '0;
    r.neg = neg;
    return r;
  endfunction

  // one restoring step, one quotient bit
  function automatic dvl_t div_step(dvl_t x, logic [DMAG_W-1:0] dm);
    dvl_t           r;
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    logic           ge;
    trial = {x.rem, x.lo[QUO_W-1]};
    diff  = trial - {1'b0, dm};
    ge    = trial >= {1'b0, dm};
    r     = x;
    r.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    r.lo  = {x.lo[QUO_W-2:0], 1'b0};
    r.quo = {x.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  // signed, saturated distance from a finished lane
  function automatic logic [WORD_WIDTH-1:0] div_result(dvl_t x);
    logic [WORD_WIDTH-1:0] q;
    logic [WORD_WIDTH-1:0] r;
    q = {1'b0, x.quo};
    if (x.ovf) begin
      r = x.neg ? {1'b1, {QUO_W{1'b0}}} : {1'b0, {QUO_W{1'b1}}};
    end else begin
      r = x.neg ? (~q + 1'b1) : q;
    end
    return r;
  endfunction

endpackage

@@ rtl/rcci_front.sv @@
// ----------------------------------------------------------------------------
// rcci_front
// accepts rays, runs the body height test and the cap plane set-up
// ----------------------------------------------------------------------------
module rcci_front import rcci_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               start,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [17:0] dir_x,
  input  logic signed [17:0] dir_y,
  input  logic signed [17:0] dir_z,
  input  logic signed [31:0] body_t,
  input  logic               pop,
  output logic               busy,
  output logic               push,
  output item_t              push_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] pending;
  logic [CNT_W-1:0] pending_next;
  logic             accept;

  logic signed [31:0] o_in [3];
  logic signed [17:0] d_in [3];
  logic signed [31:0] cc   [3];
  logic signed [17:0] ax   [3];
  logic signed [31:0] hgt;

  // stage 1
  logic               v1;
  logic signed [17:0] d1   [3];
  logic signed [49:0] dbt1 [3];
  logic signed [35:0] ad1  [3];
  logic signed [49:0] ah1  [3];
  logic signed [32:0] oc1  [3];
  // stage 2
  logic               v2;
  logic signed [17:0] d2   [3];
  logic signed [34:0] p2   [3];
  logic signed [31:0] off2 [3];
  logic signed [50:0] coa2 [3];
  logic signed [32:0] oc2  [3];
  logic signed [37:0] den2;
  // stage 3
  logic                   v3;
  logic signed [17:0]     d3   [3];
  logic signed [52:0]     pa3  [3];
  logic signed [49:0]     ko3  [3];
  logic signed [OCC_W-1:0] ocb3 [3];
  logic signed [OCC_W-1:0] oct3 [3];
  logic signed [52:0]     n0_3;
  logic signed [37:0]     den3;

  // classification terms
  logic signed [54:0] m_sum;
  logic signed [51:0] k_sum;
  logic signed [56:0] m2;
  logic signed [56:0] h2;
  logic               in_height;

  // credit count: items taken but not yet popped from the queue
  assign accept = start && !busy;
  assign busy   = pending >= CNT_W'(DEPTH);
  assign pending_next = pending + CNT_W'(accept) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  // port and register views as vectors
  always_comb begin
    o_in[0] = origin_x;
    o_in[1] = origin_y;
    o_in[2] = origin_z;
    d_in[0] = dir_x;
    d_in[1] = dir_y;
    d_in[2] = dir_z;
    for (int i = 0; i < 3; i++) begin
      cc[i] = $signed(cfg.center[i]);
      ax[i] = $signed(cfg.axis[i]);
    end
    hgt = $signed({1'b0, cfg.height});
  end

  // stage 1: first products and origin offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    for (int i = 0; i < 3; i++) begin
      d1[i]   <= d_in[i];
      dbt1[i] <= 50'(d_in[i]) * 50'(body_t);
      ad1[i]  <= 36'(d_in[i]) * 36'(ax[i]);
      ah1[i]  <= 50'(ax[i]) * 50'(hgt);
      oc1[i]  <= 33'(o_in[i]) - 33'(cc[i]);
    end
  end

  // stage 2: body point, half-height offsets, denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    for (int i = 0; i < 3; i++) begin
      d2[i]   <= d1[i];
      p2[i]   <= 35'(oc1[i]) + 35'(dbt1[i] >>> FRAC_BITS);
      off2[i] <= 32'(ah1[i] >>> (FRAC_BITS + 1));
      coa2[i] <= 51'(oc1[i]) * 51'(ax[i]);
      oc2[i]  <= oc1[i];
    end
    den2 <= 38'(ad1[0]) + 38'(ad1[1]) + 38'(ad1[2]);
  end

  // stage 3: axis projections and cap offsets
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 3; i++) begin
      d3[i]   <= d2[i];
      pa3[i]  <= 53'(p2[i]) * 53'(ax[i]);
      ko3[i]  <= 50'(off2[i]) * 50'(ax[i]);
      ocb3[i] <= OCC_W'(oc2[i]) + OCC_W'(off2[i]);
      oct3[i] <= OCC_W'(oc2[i]) - OCC_W'(off2[i]);
    end
    n0_3 <= -(53'(coa2[0]) + 53'(coa2[1]) + 53'(coa2[2]));
    den3 <= den2;
  end

  // height test and numerators, straight into the queue
  always_comb begin
    m_sum     = 55'(pa3[0]) + 55'(pa3[1]) + 55'(pa3[2]);
    k_sum     = 52'(ko3[0]) + 52'(ko3[1]) + 52'(ko3[2]);
    m2        = 57'($signed({m_sum, 1'b0}));
    h2        = 57'($signed({1'b0, cfg.height, {FRAC_BITS{1'b0}}}));
    in_height = (m2 > -h2) && (m2 < h2);

    push_item.cls   = in_height ? CLS_BODY :
                      ((den3 == '0) ? CLS_PARALLEL : CLS_CAPS);
    push_item.num_b = NUM_W'(n0_3) - NUM_W'(k_sum);
    push_item.num_t = NUM_W'(n0_3) + NUM_W'(k_sum);
    push_item.den   = den3;
    for (int i = 0; i < 3; i++) begin
      push_item.dir[i] = d3[i];
      push_item.ocb[i] = ocb3[i];
      push_item.oct[i] = oct3[i];
    end
  end

  assign push = v3;

endmodule

@@ rtl/rcci_queue.sv @@
// ----------------------------------------------------------------------------
// rcci_queue
// short item queue between front end and back end
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcci_queue import rcci_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             full;

  assign empty = count == '0;
  assign full  = count == CNT_W'(DEPTH);
  assign head  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // front credit count must keep the queue from overflowing
  `ASSERT_IMPLIES(q_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLIES(q_ptr_match, clk, rst, count == '0, wr_ptr == rd_ptr)
  `ASSERT_NEXT(q_fill, clk, rst, push && !pop, !empty)

endmodule

@@ rtl/rcci_back.sv @@
// ----------------------------------------------------------------------------
// rcci_back
// pipelined cap distance division, disc test and nearer-cap selection
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcci_back import rcci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               done,
  output logic               cap_hit,
  output logic signed [31:0] cap_t,
  output logic [1:0]         cap_side,
  output logic               in_body
);

  localparam logic [1:0] SIDE_NONE   = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_TOP    = 2'd2;

  typedef struct packed {
    cls_t                  cls;
    logic [2:0][17:0]      dir;
    logic [2:0][OCC_W-1:0] ocb;
    logic [2:0][OCC_W-1:0] oct;
    logic [DMAG_W-1:0]     dmag;
  } side_t;

  typedef struct packed {
    cls_t                  cls;
    logic [WORD_WIDTH-1:0] tb;
    logic [WORD_WIDTH-1:0] tt;
  } fin_t;

  // head register
  logic  v0;
  item_t it0;

  // divider set-up terms
  logic signed [NUM_W-1:0] nb;
  logic signed [NUM_W-1:0] nt;
  logic signed [DEN_W-1:0] dn;
  logic [NUM_W-1:0]        magb;
  logic [NUM_W-1:0]        magt;
  logic [DMAG_W-1:0]       dmag;

  // divider pipeline, stage 0 is set-up
  logic  dv [QUO_W+1];
  side_t sd [QUO_W+1];
  dvl_t  lb [QUO_W+1];
  dvl_t  lt [QUO_W+1];

  // distance stage
  logic  vt;
  side_t sdt;
  fin_t  fint;

  // disc test stages
  logic               v1;
  fin_t               fin1;
  logic signed [49:0] dtb1 [3];
  logic signed [49:0] dtt1 [3];
  logic [2:0][OCC_W-1:0] ocb1;
  logic [2:0][OCC_W-1:0] oct1;

  logic               v2;
  fin_t               fin2;
  logic [30:0]        apb2 [3];
  logic [30:0]        apt2 [3];
  logic               farb2;
  logic               fart2;

  logic               v3;
  fin_t               fin3;
  logic [61:0]        sqb3 [3];
  logic [61:0]        sqt3 [3];
  logic [61:0]        radsq3;
  logic               farb3;
  logic               fart3;

  // combinational disc terms
  logic signed [34:0] pb [3];
  logic signed [34:0] pt [3];
  logic [34:0]        apb [3];
  logic [34:0]        apt [3];
  logic               farb_c;
  logic               fart_c;
  logic [63:0]        sumb;
  logic [63:0]        sumt;
  logic               hb;
  logic               ht;

  // head register: take every item the queue offers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    it0 <= in_item;
  end

  // magnitudes and signs
  always_comb begin
    nb   = $signed(it0.num_b);
    nt   = $signed(it0.num_t);
    dn   = $signed(it0.den);
    magb = nb[NUM_W-1] ? NUM_W'(-nb) : NUM_W'(nb);
    magt = nt[NUM_W-1] ? NUM_W'(-nt) : NUM_W'(nt);
    dmag = dn[DEN_W-1] ? DMAG_W'(-dn) : DMAG_W'(dn);
  end

  // divider set-up stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v0;
    end
    sd[0].cls  <= it0.cls;
    sd[0].dir  <= it0.dir;
    sd[0].ocb  <= it0.ocb;
    sd[0].oct  <= it0.oct;
    sd[0].dmag <= dmag;
    lb[0] <= div_init(magb, nb[NUM_W-1] ^ dn[DEN_W-1], dmag);
    lt[0] <= div_init(magt, nt[NUM_W-1] ^ dn[DEN_W-1], dmag);
  end

  // one quotient bit per stage, both caps side by side
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      sd[k+1] <= sd[k];
      lb[k+1] <= div_step(lb[k], sd[k].dmag);
      lt[k+1] <= div_step(lt[k], sd[k].dmag);
    end
  end

  // saturated distances
  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else begin
      vt <= dv[QUO_W];
    end
    sdt      <= sd[QUO_W];
    fint.cls <= sd[QUO_W].cls;
    fint.tb  <= div_result(lb[QUO_W]);
    fint.tt  <= div_result(lt[QUO_W]);
  end

  // direction times distance
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= vt;
    end
    fin1 <= fint;
    ocb1 <= sdt.ocb;
    oct1 <= sdt.oct;
    for (int i = 0; i < 3; i++) begin
      dtb1[i] <= 50'($signed(sdt.dir[i])) * 50'($signed(fint.tb));
      dtt1[i] <= 50'($signed(sdt.dir[i])) * 50'($signed(fint.tt));
    end
  end

  // offsets from the cap centres and per-axis radius check
  always_comb begin
    farb_c = 1'b0;
    fart_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pb[i]  = 35'($signed(ocb1[i])) + 35'(dtb1[i] >>> FRAC_BITS);
      pt[i]  = 35'($signed(oct1[i])) + 35'(dtt1[i] >>> FRAC_BITS);
      apb[i] = pb[i][34] ? 35'(-pb[i]) : 35'(pb[i]);
      apt[i] = pt[i][34] ? 35'(-pt[i]) : 35'(pt[i]);
      farb_c = farb_c | (apb[i] > 35'(cfg.radius));
      fart_c = fart_c | (apt[i] > 35'(cfg.radius));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    fin2  <= fin1;
    farb2 <= farb_c;
    fart2 <= fart_c;
    for (int i = 0; i < 3; i++) begin
      apb2[i] <= apb[i][30:0];
      apt2[i] <= apt[i][30:0];
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    fin3   <= fin2;
    farb3  <= farb2;
    fart3  <= fart2;
    radsq3 <= 62'(cfg.radius) * 62'(cfg.radius);
    for (int i = 0; i < 3; i++) begin
      sqb3[i] <= 62'(apb2[i]) * 62'(apb2[i]);
      sqt3[i] <= 62'(apt2[i]) * 62'(apt2[i]);
    end
  end

  // disc test
  always_comb begin
    sumb = 64'(sqb3[0]) + 64'(sqb3[1]) + 64'(sqb3[2]);
    sumt = 64'(sqt3[0]) + 64'(sqt3[1]) + 64'(sqt3[2]);
    hb   = !farb3 && (sumb <= 64'(radsq3));
    ht   = !fart3 && (sumt <= 64'(radsq3));
  end

  // result register, nearer cap wins, bottom on a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      cap_hit  <= 1'b0;
      cap_t    <= '0;
      cap_side <= SIDE_NONE;
      in_body  <= 1'b0;
    end else begin
      done     <= v3;
      cap_hit  <= 1'b0;
      cap_t    <= '0;
      cap_side <= SIDE_NONE;
      in_body  <= 1'b0;
      if (v3) begin
        case (fin3.cls)
          CLS_BODY: begin
            in_body <= 1'b1;
          end
          CLS_CAPS: begin
            if (hb && (!ht || ($signed(fin3.tb) <= $signed(fin3.tt)))) begin
              cap_hit  <= 1'b1;
              cap_t    <= $signed(fin3.tb);
              cap_side <= SIDE_BOTTOM;
            end else if (ht) begin
              cap_hit  <= 1'b1;
              cap_t    <= $signed(fin3.tt);
              cap_side <= SIDE_TOP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_IMPLIES(b_hit_side, clk, rst, done && cap_hit, cap_side == SIDE_BOTTOM || cap_side == SIDE_TOP)
  `ASSERT_IMPLIES(b_body_excl, clk, rst, in_body, !cap_hit && cap_side == SIDE_NONE)
  `ASSERT_IMPLIES(b_quiet, clk, rst, !done, !cap_hit && !in_body && cap_side == SIDE_NONE)

endmodule

@@ rtl/ray_cylinder_cap_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// ray_cylinder_cap_intersect_unit
// cap intersection for a capped cylinder, Q16.16, one ray per cycle
// ----------------------------------------------------------------------------
// usage
//   configuration: APB-style port, eight registers at byte offsets 0..28
//   (centre x/y/z, axis x/y/z, radius, height); write only while idle.
//   input: a ray transaction is taken at a clock edge with start high and
//   busy low. origin, direction and the body hit distance are sampled there.
//   output: done is high for exactly one cycle per ray, in order, with
//   cap_hit, cap_t, cap_side and in_body valid in that cycle. the receiver
//   cannot stall, so the back end never holds a result.
//   result path: the front end, the queue, the 31-stage restoring divider for
//   the cap distances and the disc test stages lie between the ray and done.
//   throughput: one ray per cycle. busy follows the front end's credit count
//   of QUEUE_DEPTH items; with QUEUE_DEPTH of 5 or more it stays low.
//   reset: synchronous rst empties the pipeline and queue and loads the
//   register defaults (axis along +y, radius 1.0, height 2.0).
// ----------------------------------------------------------------------------
module ray_cylinder_cap_intersect_unit import rcci_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // rays
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [17:0] dir_x,
  input  logic signed [17:0] dir_y,
  input  logic signed [17:0] dir_z,
  input  logic signed [31:0] body_t,
  // results
  output logic               done,
  output logic               cap_hit,
  output logic signed [31:0] cap_t,
  output logic [1:0]         cap_side,
  output logic               in_body
);

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_AXIS_X   = 3'd3;
  localparam logic [2:0] REG_AXIS_Y   = 3'd4;
  localparam logic [2:0] REG_AXIS_Z   = 3'd5;
  localparam logic [2:0] REG_RADIUS   = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  cfg_t  cfg;
  logic  wr_en;
  logic  push;
  logic  pop;
  logic  empty;
  item_t push_item;
  item_t head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center <= '0;
      cfg.axis   <= {18'd0, 18'd65536, 18'd0};
      cfg.radius <= 31'd65536;
      cfg.height <= 31'd131072;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_CENTER_X: cfg.center[0] <= pwdata;
        REG_CENTER_Y: cfg.center[1] <= pwdata;
        REG_CENTER_Z: cfg.center[2] <= pwdata;
        REG_AXIS_X:   cfg.axis[0]   <= pwdata[17:0];
        REG_AXIS_Y:   cfg.axis[1]   <= pwdata[17:0];
        REG_AXIS_Z:   cfg.axis[2]   <= pwdata[17:0];
        REG_RADIUS:   cfg.radius    <= pwdata[30:0];
        REG_HEIGHT:   cfg.height    <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X: prdata = cfg.center[0];
      REG_CENTER_Y: prdata = cfg.center[1];
      REG_CENTER_Z: prdata = cfg.center[2];
      REG_AXIS_X:   prdata = 32'(cfg.axis[0]);
      REG_AXIS_Y:   prdata = 32'(cfg.axis[1]);
      REG_AXIS_Z:   prdata = 32'(cfg.axis[2]);
      REG_RADIUS:   prdata = 32'(cfg.radius);
      REG_HEIGHT:   prdata = 32'(cfg.height);
      default:      prdata = '0;
    endcase
  end

  // back end takes whatever the queue holds
  assign pop = !empty;

  rcci_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .origin_z  (origin_z),
    .dir_x     (dir_x),
    .dir_y     (dir_y),
    .dir_z     (dir_z),
    .body_t    (body_t),
    .pop       (pop),
    .busy      (busy),
    .push      (push),
    .push_item (push_item)
  );

  rcci_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  rcci_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (pop),
    .in_item  (head),
    .done     (done),
    .cap_hit  (cap_hit),
    .cap_t    (cap_t),
    .cap_side (cap_side),
    .in_body  (in_body)
  );

endmodule
